// ===== src/sha1h_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types and constants for the SHA-1 byte stream hasher: the sequencer
// states, the control bundle to the round core and the SHA-1 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1h_pkg;

    localparam int CV_WORDS   = 5;
    localparam int CV_IDX_W   = 3;
    localparam int ROUNDS     = 80;
    localparam int ROUND_W    = 7;
    localparam int WORDS_BLK  = 16;
    localparam int POS_W      = 6;
    localparam int BYTE_CNT_W = 61;

    localparam logic [ROUND_W-1:0]  LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [POS_W-1:0]    LAST_POS   = 6'd63;
    localparam logic [POS_W-1:0]    LEN_POS    = 6'd56;
    localparam logic [7:0]          PAD_MARK   = 8'o200;
    localparam logic [CV_IDX_W-1:0] LAST_WORD_IDX = CV_IDX_W'(CV_WORDS - 1);

    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               push_word;
        logic [31:0]        word;
        logic               start;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               finish;
        logic               init;
    } core_ctl_t;

endpackage

`default_nettype wire

// ===== src/sha1h_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round core
// Holds the sixteen-word schedule line, the working variables and the
// chaining value, and runs one SHA-1 round per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1h_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sha1h_pkg::core_ctl_t               ctl,
    input  wire logic [sha1h_pkg::CV_IDX_W-1:0]     rd_idx,
    output logic [31:0]                             cv_word
);

    logic [31:0] cv_reg [sha1h_pkg::CV_WORDS];
    logic [31:0] w_reg  [sha1h_pkg::WORDS_BLK];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] sched_x;
    logic [31:0] sched_word;
    logic [31:0] t_val;
    logic [31:0] w_in;

    always_comb
    begin
        if (ctl.round_idx inside {[0:19]})
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1h_pkg::K_0;
        end
        else if (ctl.round_idx inside {[20:39]})
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1h_pkg::K_1;
        end
        else if (ctl.round_idx inside {[40:59]})
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1h_pkg::K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1h_pkg::K_3;
        end

        // The line always shows the current round's word at tap 0.
        sched_x    = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        sched_word = {sched_x[30:0], sched_x[31]};
        t_val      = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
        w_in       = ctl.push_word ? ctl.word : sched_word;
        cv_word    = cv_reg[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= sha1h_pkg::IV_0;
            cv_reg[1] <= sha1h_pkg::IV_1;
            cv_reg[2] <= sha1h_pkg::IV_2;
            cv_reg[3] <= sha1h_pkg::IV_3;
            cv_reg[4] <= sha1h_pkg::IV_4;
        end
        else if (ctl.init)
        begin
            cv_reg[0] <= sha1h_pkg::IV_0;
            cv_reg[1] <= sha1h_pkg::IV_1;
            cv_reg[2] <= sha1h_pkg::IV_2;
            cv_reg[3] <= sha1h_pkg::IV_3;
            cv_reg[4] <= sha1h_pkg::IV_4;
        end
        else if (ctl.finish)
        begin
            cv_reg[0] <= cv_reg[0] + a_reg;
            cv_reg[1] <= cv_reg[1] + b_reg;
            cv_reg[2] <= cv_reg[2] + c_reg;
            cv_reg[3] <= cv_reg[3] + d_reg;
            cv_reg[4] <= cv_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push_word || ctl.round_en)
        begin
            for (int i = 0; i < sha1h_pkg::WORDS_BLK - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[sha1h_pkg::WORDS_BLK - 1] <= w_in;
        end

        if (ctl.start)
        begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
            e_reg <= cv_reg[4];
        end
        else if (ctl.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/sha1_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Top level: input handshake, byte packing, padding sequencer, length
// counter and the digest output channel around the SHA-1 round core.
// ----------------------------------------------------------------------------
// A message arrives one item per byte; an item may carry a byte, mark the
// end of the message, or both. A plain byte item is stored and the block
// stays ready for the next item. The item that fills a 64-byte block is
// stored, then runs 80 rounds on the shared round core, and then the
// working variables are folded into the chaining value; the round count
// is what sets the block cost. An end-of-message item then feeds the
// padding bytes (0x80, zeros up to position 56 of the block, then the
// 64-bit big-endian bit length) at one byte per cycle, running one or two
// more compressions, and finally presents the five digest words, most
// significant first, one per accepted output item, with word_index 0 to 4
// and last_word on the fifth. in_ready is low from the end-of-message item
// until the fifth word has been taken, after which the block is set up for
// the next message. The bit length counts modulo 2^64.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hasher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sha1h_pkg::state_t state_reg, state_next;

    logic [sha1h_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [sha1h_pkg::BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [sha1h_pkg::ROUND_W-1:0]    rnd_reg, rnd_next;
    logic [sha1h_pkg::CV_IDX_W-1:0]   oidx_reg, oidx_next;
    logic [23:0]                      acc_reg, acc_next;
    logic                             pad_active_reg, pad_active_next;
    logic                             first_reg, first_next;
    logic                             len_flag_reg, len_flag_next;

    logic [63:0]          len_bits;
    logic [7:0]           pad_byte;
    logic [7:0]           put_val;
    logic                 put_en;
    logic                 block_full;
    logic [31:0]          cv_word;
    sha1h_pkg::core_ctl_t ctl;

    sha1h_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_idx  (oidx_reg),
        .cv_word (cv_word)
    );

    assign len_bits = {cnt_reg, 3'b000};

    // Byte insertion path, shared by message bytes and padding bytes.
    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = sha1h_pkg::PAD_MARK;
        end
        else if (len_flag_reg || (pos_reg == sha1h_pkg::LEN_POS))
        begin
            // Position 56 carries the top length byte, position 63 the bottom.
            pad_byte = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end

        put_en     = ((state_reg == sha1h_pkg::ST_IDLE) && in_valid && has_byte) ||
                     (state_reg == sha1h_pkg::ST_PAD);
        put_val    = (state_reg == sha1h_pkg::ST_PAD) ? pad_byte : data_byte;
        block_full = put_en && (pos_reg == sha1h_pkg::LAST_POS);
    end

    // Sequencer: next state and control outputs.
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        rnd_next        = rnd_reg;
        oidx_next       = oidx_reg;
        acc_next        = acc_reg;
        pad_active_next = pad_active_reg;
        first_next      = first_reg;
        len_flag_next   = len_flag_reg;

        ctl           = '0;
        ctl.word      = {acc_reg, put_val};
        ctl.push_word = put_en && (pos_reg[1:0] == 2'b11);
        ctl.start     = block_full;
        ctl.round_idx = rnd_reg;

        if (put_en)
        begin
            pos_next = pos_reg + 1'b1;
            acc_next = {acc_reg[15:0], put_val};
        end

        case (state_reg)
            sha1h_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (block_full)
                    begin
                        pad_active_next = end_of_message;
                        first_next      = end_of_message;
                        rnd_next        = '0;
                        state_next      = sha1h_pkg::ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        pad_active_next = 1'b1;
                        first_next      = 1'b1;
                        state_next      = sha1h_pkg::ST_PAD;
                    end
                end
            end

            sha1h_pkg::ST_PAD:
            begin
                first_next = 1'b0;
                if (!first_reg && (pos_reg == sha1h_pkg::LEN_POS))
                begin
                    len_flag_next = 1'b1;
                end
                if (block_full)
                begin
                    rnd_next   = '0;
                    state_next = sha1h_pkg::ST_ROUND;
                end
            end

            sha1h_pkg::ST_ROUND:
            begin
                ctl.round_en = 1'b1;
                rnd_next     = rnd_reg + 1'b1;
                if (rnd_reg == sha1h_pkg::LAST_ROUND)
                begin
                    state_next = sha1h_pkg::ST_ADD;
                end
            end

            sha1h_pkg::ST_ADD:
            begin
                ctl.finish = 1'b1;
                if (len_flag_reg)
                begin
                    oidx_next  = '0;
                    state_next = sha1h_pkg::ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = sha1h_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha1h_pkg::ST_IDLE;
                end
            end

            sha1h_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (oidx_reg == sha1h_pkg::LAST_WORD_IDX)
                    begin
                        // Digest delivered: start over for the next message.
                        ctl.init        = 1'b1;
                        cnt_next        = '0;
                        pad_active_next = 1'b0;
                        len_flag_next   = 1'b0;
                        state_next      = sha1h_pkg::ST_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = sha1h_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sha1h_pkg::ST_IDLE;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            rnd_reg        <= '0;
            oidx_reg       <= '0;
            pad_active_reg <= 1'b0;
            first_reg      <= 1'b0;
            len_flag_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            rnd_reg        <= rnd_next;
            oidx_reg       <= oidx_next;
            pad_active_reg <= pad_active_next;
            first_reg      <= first_next;
            len_flag_reg   <= len_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // The chaining value and word index are registers that hold still while
    // a digest word waits, so the output fields are stable under a stall.
    assign in_ready    = (state_reg == sha1h_pkg::ST_IDLE);
    assign out_valid   = (state_reg == sha1h_pkg::ST_OUT);
    assign digest_word = cv_word;
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == sha1h_pkg::LAST_WORD_IDX);

endmodule

`default_nettype wire

// ===== src/sha1h_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher port checker
// Watches the top level's ports for the digest word sequence and the
// exclusive use of the input and output sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1h_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);

    // A waiting digest word holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) &&
                                    $stable(word_index))
        else $error("digest word changed while stalled");

    // Input is never taken while a digest is being delivered.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during digest output");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd4)))
        else $error("last_word does not match word_index");

    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && (word_index == 3'($past(word_index) + 3'd1)))
        else $error("digest words out of sequence");

    a_end_digest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid && in_ready)
        else $error("block did not return to input after final word");

endmodule

bind sha1_byte_stream_hasher sha1h_checker u_sha1h_checker (.*);

`default_nettype wire

// ===== test/sha1_byte_stream_hasher_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Sends messages one item per byte, with random idle cycles on both sides and
// one long output stall. A software SHA-1 tracker predicts the five digest
// words for every message, and every digest word that leaves the block is
// checked against them.
// ----------------------------------------------------------------------------

// Tracks the message that the block is hashing and holds the digest words
// that the block still owes. It mirrors the chaining value, the 64-byte block
// buffer and the 64-bit bit length of the hardware.
class sha1_digest_tracker;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    logic [31:0]  chain [5];
    logic [7:0]   block_bytes [64];
    logic [63:0]  bit_len;
    int unsigned  fill;
    digest_word_t owed_words [$];
    int unsigned  mismatches;
    int unsigned  words_checked;
    int unsigned  messages;

    function new();
        restart();
        fill          = 0;
        mismatches    = 0;
        words_checked = 0;
        messages      = 0;
    endfunction

    // Back to the SHA-1 initial values with an empty message.
    function void restart();
        chain[0] = 32'h67452301;
        chain[1] = 32'hEFCDAB89;
        chain[2] = 32'h98BADCFE;
        chain[3] = 32'h10325476;
        chain[4] = 32'hC3D2E1F0;
        bit_len  = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One 80-round compression of the buffered block into the chain.
    function void compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wi, t;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                    block_bytes[4*i+2], block_bytes[4*i+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i >= 16)
            begin
                wi = rotl(w[(i+13)%16] ^ w[(i+8)%16] ^ w[(i+2)%16] ^ w[i%16], 1);
                w[i%16] = wi;
            end
            else
                wi = w[i];
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + wi;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function void push_byte(logic [7:0] v);
        block_bytes[fill] = v;
        fill = (fill + 1) % 64;
        if (fill == 0)
            compress();
    endfunction

    // Called for every accepted input item.
    function void note_item(logic [7:0] data, logic has, logic eom);
        logic [63:0]  len;
        digest_word_t dw;
        fill = bit_len[8:3];
        if (has)
        begin
            push_byte(data);
            bit_len += 64'd8;
        end
        if (!eom)
            return;
        len = bit_len;
        push_byte(8'h80);
        while (fill != 56)
            push_byte(8'h00);
        for (int i = 0; i < 8; i++)
            push_byte(len[63 - 8*i -: 8]);
        for (int i = 0; i < 5; i++)
        begin
            dw.word = chain[i];
            dw.idx  = 3'(i);
            dw.last = (i == 4);
            owed_words.push_back(dw);
        end
        messages++;
        restart();
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Called for every accepted digest word.
    task check_word(logic [31:0] word, logic [2:0] idx, logic last);
        digest_word_t want;
        if (owed_words.size() == 0)
        begin
            report_mismatch($sformatf("digest word %08h (index %0d) with none owed",
                                      word, idx));
            return;
        end
        want = owed_words.pop_front();
        words_checked++;
        if (word !== want.word)
            report_mismatch($sformatf("digest_word %08h, predicted %08h at index %0d",
                                      word, want.word, want.idx));
        if (idx !== want.idx)
            report_mismatch($sformatf("word_index %0d, predicted %0d", idx, want.idx));
        if (last !== want.last)
            report_mismatch($sformatf("last_word %0b, predicted %0b at index %0d",
                                      last, want.last, want.idx));
    endtask

endclass

module sha1_byte_stream_hasher_tb;

    // Number of counted input items (bytes and ends of message) to send.
    localparam int ITEM_TARGET = 370;
    // Output hold-off that fills the block and backs up the input side.
    localparam int HOLD_CYCLES = 400;
    // Idle percentage on either side outside the quiet window.
    localparam int IDLE_PCT = 10;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [7:0]  data_byte      = 8'h00;
    logic        has_byte       = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_ready      = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha1_digest_tracker tracker = new();

    int  items_sent   = 0;
    int  noise_sent   = 0;
    bit  hold_armed   = 1'b0;
    int  hold_count;
    int  drain_cycles;

    // While the count of sent items lies from 120 to 219, neither side idles at all.
    wire quiet_window = (items_sent >= 120) && (items_sent < 220);

    sha1_byte_stream_hasher dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #1 clk = ~clk;

    // Both handshakes are sampled at the rising edge. The block's outputs
    // there still hold their values from before the edge, so the tracker
    // sees exactly what the block sees. An input item is noted before a
    // digest word is checked; a digest can never leave in the cycle that
    // its end-of-message item is taken.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tracker.note_item(data_byte, has_byte, end_of_message);
        if (rst_n && out_valid && out_ready)
            tracker.check_word(digest_word, word_index, last_word);
    end

    // Offers one item from a falling edge and returns just after the rising
    // edge that takes it. A random number of idle cycles may come first.
    // Valid is written at most once per falling edge, and it stays high
    // with the payload steady until the block takes the item.
    task send_item(input logic [7:0] d, input logic h, input logic e, input bit counted);
        @(negedge clk);
        while (!quiet_window && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        data_byte      = d;
        has_byte       = h;
        end_of_message = e;
        do
            @(posedge clk);
        while (!in_ready);
        if (counted)
            items_sent++;
        else
            noise_sent++;
    endtask

    // Sends a message of len bytes. With noise, empty items (no byte and no
    // end) are mixed in; they must leave the message untouched. The end of
    // the message rides on the last byte or comes as an item of its own.
    task send_message(input int len, input bit noisy);
        bit fold;
        fold = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && ($urandom_range(0, 99) < 10))
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, fold && (i == len - 1), 1'b1);
        end
        if (!fold)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
    endtask

    // Mostly short messages, plenty around the 55/56 and 64 byte padding
    // boundaries, and a few of 110 to 130 bytes that run over one full block.
    function int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 10);
        else if (r < 90)
            return $urandom_range(52, 68);
        else
            return $urandom_range(110, 130);
    endfunction

    // Receiver. It idles at random, except in the quiet window, and once
    // holds off for a long count of cycles when a digest is waiting, so the
    // block cannot finish its output and the sender's next item backs up.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_armed && out_valid)
            begin
                out_ready  = 1'b0;
                hold_armed = 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    hold_count++;
                end
            end
            else
                out_ready = quiet_window || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // An empty item straight after reset must do nothing.
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        // Empty message: end with no byte, and the data field is ignored.
        send_item(8'hA5, 1'b0, 1'b1, 1'b1);
        // The classic three-byte message, end carried on the last byte.
        send_item(8'h61, 1'b1, 1'b0, 1'b1);
        send_item(8'h62, 1'b1, 1'b0, 1'b1);
        send_item(8'h63, 1'b1, 1'b1, 1'b1);
        // Single byte at the top of the range, byte and end in one item.
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        // Zero byte, an empty item in the middle, then an end on its own.
        send_item(8'h00, 1'b1, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        // Both extremes in one message, then two empty messages back to back.
        send_item(8'hFF, 1'b1, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1, 1'b1);

        // The digest of the last directed message meets the long hold-off.
        hold_armed = 1'b1;
        while (items_sent < ITEM_TARGET)
            send_message(pick_length(), 1'b1);

        @(negedge clk);
        in_valid = 1'b0;

        drain_cycles = 0;
        while ((tracker.owed_words.size() != 0) && (drain_cycles < 20000))
        begin
            @(posedge clk);
            drain_cycles++;
        end

        if (tracker.owed_words.size() != 0)
        begin
            $display("Timed out with %0d digest words still owed.",
                     tracker.owed_words.size());
            $display("sha1_byte_stream_hasher_tb: errors");
            $finish;
        end
        else
        begin
            // Leave room for any stray word the block might still emit.
            repeat (200) @(posedge clk);
            $display("Hashed %0d messages from %0d byte and end items plus %0d empty items.",
                     tracker.messages, items_sent, noise_sent);
            $display("Checked %0d digest words, with %0d mismatches.",
                     tracker.words_checked, tracker.mismatches);
            if (tracker.mismatches == 0)
                $display("sha1_byte_stream_hasher_tb: clean");
            else
                $display("sha1_byte_stream_hasher_tb: errors");
            $finish;
        end
    end

    // Hard limit, far above the slowest correct run.
    initial
    begin
        #600000;
        $display("Run limit reached before the end of the stimulus.");
        $display("sha1_byte_stream_hasher_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sha1h_pkg.sv
src/sha1h_core.sv
src/sha1_byte_stream_hasher.sv
src/sha1h_checker.sv
test/sha1_byte_stream_hasher_tb.sv
